[rtl/led_pixel_timed_crossfade_top_defines.svh]
// Assertion macros used by the crossfade engine checker.
`ifndef LED_PIXEL_TIMED_CROSSFADE_TOP_DEFINES_SVH
`define LED_PIXEL_TIMED_CROSSFADE_TOP_DEFINES_SVH
// Clocked property, disabled while reset is high.
`define LPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("crossfade engine assertion failed");
// Condition that must never hold at a clock edge.
`define LPC_NEVER(lbl, clk, rst, cond) `LPC_ASSERT(lbl, clk, rst, !(cond))
`endif

[rtl/lpc_pkg.sv]
// Types, constants and codes of the LED pixel crossfade engine.
package lpc_pkg;
   localparam int MAX_PIXELS_DEF = 64;
   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] PIXEL_COUNT_RESET = 7'd64;
   localparam logic [16:0] Q_ONE = 17'h10000;
   localparam logic [16:0] P_MIN = 17'd655;
   localparam int DIV_STEPS = 48;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] OP_SET  = 2'd0;
   localparam logic [1:0] OP_FADE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_READ = 2'd3;

   typedef enum logic [2:0] {
      CMD_SET, CMD_FADE, CMD_TICK, CMD_READ, CMD_ERR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [7:0]        pixel_index;
      logic [23:0]       colour;
      logic [31:0]       fade_start;
      logic [31:0]       fade_duration;
      logic [31:0]       now_ms;
      logic [CNT_W-1:0]  count;
   } cmd_type;

   typedef struct packed {
      logic [23:0] cur;
      logic [23:0] start;
      logic [23:0] tgt;
      logic [31:0] begin_time;
      logic [31:0] length;
   } pix_rec_type;

   typedef struct packed {
      logic [5:0]  out_index;
      logic [23:0] colour;
      logic        strip_changed;
      logic        all_filled;
      logic        index_error;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_OP, ST_TREAD, ST_TEVAL, ST_DIV, ST_BLEND,
      ST_BWRITE, ST_TDONE, ST_EREAD, ST_EMIT, ST_REPLY
   } state_type;
endpackage

[rtl/lpc_if.sv]
// Channel interfaces: request, response and configuration write.
interface lpc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  pixel_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [31:0] fade_start;
   logic [31:0] fade_duration;
   logic [31:0] now_ms;
   modport source (output valid, opcode, pixel_index, red, green, blue, fade_start,
                   fade_duration, now_ms, input ready);
   modport sink (input valid, opcode, pixel_index, red, green, blue, fade_start,
                 fade_duration, now_ms, output ready);
endinterface

interface lpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] out_index;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       strip_changed;
   logic       all_filled;
   logic       index_error;
   logic       last_of_run;
   modport source (output valid, out_index, out_red, out_green, out_blue, strip_changed,
                   all_filled, index_error, last_of_run, input ready);
   modport sink (input valid, out_index, out_red, out_green, out_blue, strip_changed,
                 all_filled, index_error, last_of_run, output ready);
endinterface

interface lpc_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] pixel_count;
   modport source (output valid, pixel_count, input ready);
   modport sink (input valid, pixel_count, output ready);
endinterface

[rtl/lpc_front.sv]
// Front end: pixel count register, request decode and index check.
module lpc_front #(
   parameter int MAX_PIXELS = lpc_pkg::MAX_PIXELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   lpc_req_if.sink          req,
   lpc_csr_if.sink          csr,
   input  logic             q_ready,
   output logic             q_push,
   output lpc_pkg::cmd_type q_cmd
);
   logic [lpc_pkg::CNT_W-1:0] pixel_count_ff, pixel_count_in;
   logic [lpc_pkg::CNT_W-1:0] used;

   assign csr.ready = 1'b1;
   assign pixel_count_in = (csr.valid) ? csr.pixel_count : pixel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= lpc_pkg::PIXEL_COUNT_RESET;
      end else begin
         pixel_count_ff <= pixel_count_in;
      end
   end

   always_comb begin
      if (pixel_count_ff == '0) begin
         used = lpc_pkg::CNT_W'(1);
      end else if (pixel_count_ff > lpc_pkg::CNT_W'(MAX_PIXELS)) begin
         used = lpc_pkg::CNT_W'(MAX_PIXELS);
      end else begin
         used = pixel_count_ff;
      end
   end

   assign req.ready = q_ready;
   assign q_push    = req.valid && q_ready;

   always_comb begin
      q_cmd.pixel_index   = req.pixel_index;
      q_cmd.colour        = {req.red, req.green, req.blue};
      q_cmd.fade_start    = req.fade_start;
      q_cmd.fade_duration = req.fade_duration;
      q_cmd.now_ms        = req.now_ms;
      q_cmd.count         = used;
      case (req.opcode)
         lpc_pkg::OP_SET:  q_cmd.kind = lpc_pkg::CMD_SET;
         lpc_pkg::OP_FADE: q_cmd.kind = lpc_pkg::CMD_FADE;
         lpc_pkg::OP_TICK: q_cmd.kind = lpc_pkg::CMD_TICK;
         lpc_pkg::OP_READ: q_cmd.kind = lpc_pkg::CMD_READ;
         default:          q_cmd.kind = lpc_pkg::CMD_READ;
      endcase
      // bad index turns any addressed op into an error reply
      if (req.opcode != lpc_pkg::OP_TICK && {1'b0, req.pixel_index} >= {2'b0, used}) begin
         q_cmd.kind = lpc_pkg::CMD_ERR;
      end
   end
endmodule

[rtl/lpc_queue.sv]
// Two-entry command queue between front and back end.
module lpc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lpc_pkg::cmd_type push_cmd,
   output logic             ready,
   input  logic             pop,
   output logic             valid,
   output lpc_pkg::cmd_type head
);
   localparam int PW = (lpc_pkg::QUEUE_DEPTH > 1) ? $clog2(lpc_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(lpc_pkg::QUEUE_DEPTH + 1);

   lpc_pkg::cmd_type entry_ff [lpc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;

   assign ready = fill_ff != CW'(lpc_pkg::QUEUE_DEPTH);
   assign valid = fill_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(lpc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(lpc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

[rtl/lpc_back.sv]
// Back end: pixel memory, tick sweep with serial divider and blend, result register.
module lpc_back #(
   parameter int MAX_PIXELS = lpc_pkg::MAX_PIXELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  lpc_pkg::cmd_type q_cmd,
   output logic             q_pop,
   lpc_rsp_if.source        rsp
);
   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW = lpc_pkg::CNT_W;

   lpc_pkg::state_type    state_ff, state_in;
   lpc_pkg::cmd_type      cmd_ff, cmd_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  any_ff, any_in;
   logic                  filled_ff, filled_in;
   lpc_pkg::pix_rec_type  hold_ff, hold_in;
   logic [47:0]           num_ff, num_in;
   logic [31:0]           rem_ff, rem_in;
   logic [5:0]            dcnt_ff, dcnt_in;
   logic [25:0]           blend_ff [3];
   logic [25:0]           blend_in [3];
   lpc_pkg::rsp_type      pend_ff, pend_in;
   lpc_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   lpc_pkg::pix_rec_type  mem [MAX_PIXELS];
   logic [MAX_PIXELS-1:0] vld_ff;
   lpc_pkg::pix_rec_type  rd_data_ff;
   logic                  rd_vld_ff;
   lpc_pkg::pix_rec_type  rec;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic                  we;
   lpc_pkg::pix_rec_type  wdata;

   logic                  out_free, last_pix;
   logic [32:0]           div_r, div_diff;
   logic                  div_ge;
   logic [16:0]           p, p_inv;
   logic [23:0]           blended;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign last_pix = (cnt_ff + 1'b1) == cmd_ff.count;
   assign rec      = rd_vld_ff ? rd_data_ff : '0;

   // pixel memory: one read, one write per cycle; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wdata;
      end
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr] && !(we && wr_addr == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // one quotient bit per step
   assign div_r    = {rem_ff, num_ff[47]};
   assign div_diff = div_r - {1'b0, hold_ff.length};
   assign div_ge   = !div_diff[32];

   always_comb begin
      if (num_ff > 48'(lpc_pkg::Q_ONE)) begin
         p = lpc_pkg::Q_ONE;
      end else if (num_ff < 48'(lpc_pkg::P_MIN)) begin
         p = lpc_pkg::P_MIN;
      end else begin
         p = num_ff[16:0];
      end
      p_inv = lpc_pkg::Q_ONE - p;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         blend_in[k] = 26'(hold_ff.start[8*k +: 8] * p_inv) + 26'(hold_ff.tgt[8*k +: 8] * p);
         blended[8*k +: 8] = (hold_ff.cur[8*k +: 8] != hold_ff.tgt[8*k +: 8])
                             ? blend_ff[k][23:16] : hold_ff.cur[8*k +: 8];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpc_pkg::ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.kind)
                  lpc_pkg::CMD_ERR:  state_in = lpc_pkg::ST_REPLY;
                  lpc_pkg::CMD_TICK: state_in = lpc_pkg::ST_TREAD;
                  default:           state_in = lpc_pkg::ST_READ;
               endcase
            end
         end
         lpc_pkg::ST_READ:  state_in = lpc_pkg::ST_OP;
         lpc_pkg::ST_OP:    state_in = lpc_pkg::ST_REPLY;
         lpc_pkg::ST_TREAD: state_in = lpc_pkg::ST_TEVAL;
         lpc_pkg::ST_TEVAL: begin
            if (cmd_ff.now_ms >= rec.begin_time && rec.cur != rec.tgt && rec.length != '0) begin
               state_in = lpc_pkg::ST_DIV;
            end else if (last_pix) begin
               state_in = lpc_pkg::ST_TDONE;
            end else begin
               state_in = lpc_pkg::ST_TREAD;
            end
         end
         lpc_pkg::ST_DIV: begin
            if (dcnt_ff == 6'(lpc_pkg::DIV_STEPS - 1)) begin
               state_in = lpc_pkg::ST_BLEND;
            end
         end
         lpc_pkg::ST_BLEND:  state_in = lpc_pkg::ST_BWRITE;
         lpc_pkg::ST_BWRITE: state_in = last_pix ? lpc_pkg::ST_TDONE : lpc_pkg::ST_TREAD;
         lpc_pkg::ST_TDONE:  state_in = any_ff ? lpc_pkg::ST_EREAD : lpc_pkg::ST_REPLY;
         lpc_pkg::ST_EREAD:  state_in = lpc_pkg::ST_EMIT;
         lpc_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = last_pix ? lpc_pkg::ST_IDLE : lpc_pkg::ST_EREAD;
            end
         end
         lpc_pkg::ST_REPLY: begin
            if (out_free) begin
               state_in = lpc_pkg::ST_IDLE;
            end
         end
         default: state_in = lpc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      any_in       = any_ff;
      filled_in    = filled_ff;
      hold_in      = hold_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      q_pop        = 1'b0;
      we           = 1'b0;
      wdata        = rec;
      wr_addr      = cnt_ff[AW-1:0];
      rd_addr      = cnt_ff[AW-1:0];
      case (state_ff)
         lpc_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               cnt_in = '0;
               any_in = 1'b0;
               pend_in = '0;
               pend_in.all_filled  = filled_ff;
               pend_in.index_error = q_cmd.kind == lpc_pkg::CMD_ERR;
               pend_in.last_of_run = 1'b1;
            end
         end
         lpc_pkg::ST_READ: begin
            rd_addr = cmd_ff.pixel_index[AW-1:0];
         end
         lpc_pkg::ST_OP: begin
            rd_addr = cmd_ff.pixel_index[AW-1:0];
            wr_addr = cmd_ff.pixel_index[AW-1:0];
            case (cmd_ff.kind)
               lpc_pkg::CMD_SET: begin
                  we          = 1'b1;
                  wdata.cur   = cmd_ff.colour;
                  wdata.start = cmd_ff.colour;
                  wdata.tgt   = cmd_ff.colour;
               end
               lpc_pkg::CMD_FADE: begin
                  we               = 1'b1;
                  wdata.start      = rec.cur;
                  wdata.tgt        = cmd_ff.colour;
                  wdata.begin_time = cmd_ff.fade_start;
                  wdata.length     = cmd_ff.fade_duration;
               end
               default: we = 1'b0;
            endcase
            pend_in.out_index = 6'(cmd_ff.pixel_index);
            pend_in.colour    = wdata.cur;
         end
         lpc_pkg::ST_TEVAL: begin
            hold_in = rec;
            if (cmd_ff.now_ms < rec.begin_time) begin
               any_in = 1'b1;
            end else if (rec.cur != rec.tgt) begin
               any_in = 1'b1;
               if (rec.length == '0) begin
                  we        = 1'b1;
                  wdata.cur = rec.tgt;
               end
            end
            num_in  = {cmd_ff.now_ms - rec.begin_time, 16'h0000};
            rem_in  = '0;
            dcnt_in = '0;
            if (!(cmd_ff.now_ms >= rec.begin_time && rec.cur != rec.tgt
                  && rec.length != '0)) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lpc_pkg::ST_DIV: begin
            rem_in  = div_ge ? div_diff[31:0] : div_r[31:0];
            num_in  = {num_ff[46:0], div_ge};
            dcnt_in = dcnt_ff + 1'b1;
         end
         lpc_pkg::ST_BWRITE: begin
            we        = 1'b1;
            wdata     = hold_ff;
            wdata.cur = blended;
            cnt_in    = cnt_ff + 1'b1;
         end
         lpc_pkg::ST_TDONE: begin
            // last pixel advanced the count past the run; restart for the report
            cnt_in    = '0;
            filled_in = !any_ff;
            pend_in   = '0;
            pend_in.all_filled  = !any_ff;
            pend_in.last_of_run = 1'b1;
         end
         lpc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.out_index     = 6'(cnt_ff);
               rsp_in.colour        = rec.cur;
               rsp_in.strip_changed = 1'b1;
               rsp_in.last_of_run   = last_pix;
               cnt_in               = cnt_ff + 1'b1;
            end
         end
         lpc_pkg::ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
            end
         end
         default: we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpc_pkg::ST_IDLE;
         filled_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      cnt_ff  <= cnt_in;
      any_ff  <= any_in;
      hold_ff <= hold_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      dcnt_ff <= dcnt_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      for (int k = 0; k < 3; k++) begin
         blend_ff[k] <= blend_in[k];
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_index     = rsp_ff.out_index;
   assign rsp.out_red       = rsp_ff.colour[23:16];
   assign rsp.out_green     = rsp_ff.colour[15:8];
   assign rsp.out_blue      = rsp_ff.colour[7:0];
   assign rsp.strip_changed = rsp_ff.strip_changed;
   assign rsp.all_filled    = rsp_ff.all_filled;
   assign rsp.index_error   = rsp_ff.index_error;
   assign rsp.last_of_run   = rsp_ff.last_of_run;
endmodule

[rtl/led_pixel_timed_crossfade_top.sv]
// Top level of the LED pixel timed crossfade engine.
// Set, fade and read requests pass through read, operate and reply states in the back end,
// requests with a bad index straight to the reply. A tick walks the pixels in use one at a
// time through the pixel memory: a pixel that does not move is read and checked, and a pixel
// in a fade goes through a 48-step serial divider that forms the fade proportion, then a
// blend state and a write. If any pixel was pending or not at its target, the strip is reported
// one result at a time, each read from the pixel memory before it is emitted, as the response side takes them.
// A two-entry queue holds requests while the back end works.
module led_pixel_timed_crossfade_top #(
   parameter int MAX_PIXELS = lpc_pkg::MAX_PIXELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lpc_req_if.sink    req_ch,
   lpc_rsp_if.source  rsp_ch,
   lpc_csr_if.sink    csr_ch
);
   logic             q_push, q_ready, q_valid, q_pop;
   lpc_pkg::cmd_type push_cmd, head_cmd;

   lpc_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .csr     (csr_ch),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_cmd   (push_cmd)
   );

   lpc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .ready    (q_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (head_cmd)
   );

   lpc_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (head_cmd),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );
endmodule

[rtl/lpc_checker.sv]
// Port-level checks of the crossfade engine and their binding to the top level.
`include "led_pixel_timed_crossfade_top_defines.svh"
module lpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] out_index,
   input logic [7:0] out_red,
   input logic [7:0] out_green,
   input logic [7:0] out_blue,
   input logic       strip_changed,
   input logic       all_filled,
   input logic       index_error,
   input logic       last_of_run
);
   `LPC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_index))
   `LPC_ASSERT(a_err_reply, clock, reset, rsp_valid && index_error |-> last_of_run && out_index == 6'd0 && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
   `LPC_NEVER(a_changed_filled, clock, reset, rsp_valid && strip_changed && (all_filled || index_error))
endmodule

bind led_pixel_timed_crossfade_top lpc_checker u_lpc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .out_index     (rsp_ch.out_index),
   .out_red       (rsp_ch.out_red),
   .out_green     (rsp_ch.out_green),
   .out_blue      (rsp_ch.out_blue),
   .strip_changed (rsp_ch.strip_changed),
   .all_filled    (rsp_ch.all_filled),
   .index_error   (rsp_ch.index_error),
   .last_of_run   (rsp_ch.last_of_run)
);

[tb/sv/tb_led_pixel_timed_crossfade_top.sv]
// Testbench of the LED pixel timed crossfade engine: random and directed requests, checked results.
module tb_led_pixel_timed_crossfade_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]  opcode;
      logic [7:0]  pixel_index;
      logic [23:0] colour;
      logic [31:0] fade_start;
      logic [31:0] fade_duration;
      logic [31:0] now_ms;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   lpc_req_if req_ch ();
   lpc_rsp_if rsp_ch ();
   lpc_csr_if csr_ch ();

   led_pixel_timed_crossfade_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   // strip model
   logic [23:0] cur_col [64];
   logic [23:0] start_col [64];
   logic [23:0] tgt_col [64];
   logic [31:0] begin_ms [64];
   logic [31:0] length_ms [64];
   logic        filled;
   logic [6:0]  strip_len;

   request_type         pending_requests [$];
   lpc_pkg::rsp_type    expected_colours [$];
   int       mismatches = 0;
   int       idle_pct = 20;
   int       quiet_cycles = 0;
   bit       hold_req = 1'b0;
   bit       req_accepted = 1'b0;

   function automatic int pixels_in_use();
      if (strip_len == 0) return 1;
      if (strip_len > 64) return 64;
      return strip_len;
   endfunction

   function automatic logic [7:0] blend(logic [7:0] s, logic [7:0] t, logic [16:0] p);
      logic [40:0] acc;
      acc = 41'(s) * (41'h10000 - 41'(p)) + 41'(t) * 41'(p);
      return acc[23:16];
   endfunction

   function automatic void push_result(int idx, logic [23:0] col, bit chg, bit fil, bit err);
      lpc_pkg::rsp_type r;
      r.out_index = idx[5:0];
      r.colour = col;
      r.strip_changed = chg;
      r.all_filled = fil;
      r.index_error = err;
      r.last_of_run = 1'b1;
      expected_colours.push_back(r);
   endfunction

   task automatic predict_crossfade(request_type rq);
      int n;
      bit any;
      logic [63:0] q;
      logic [16:0] p;
      logic [23:0] res;
      n = pixels_in_use();
      any = 0;
      if (rq.opcode == lpc_pkg::OP_TICK) begin
         for (int i = 0; i < n; i++) begin
            if (rq.now_ms < begin_ms[i]) begin
               any = 1;
               continue;
            end
            if (cur_col[i] == tgt_col[i]) continue;
            any = 1;
            if (length_ms[i] == 0) begin
               cur_col[i] = tgt_col[i];
            end else begin
               q = ({32'd0, rq.now_ms - begin_ms[i]} << 16) / {32'd0, length_ms[i]};
               if (q < 655) q = 655;
               if (q > 65536) q = 65536;
               p = q[16:0];
               for (int k = 0; k < 3; k++) begin
                  if (cur_col[i][8*k +: 8] != tgt_col[i][8*k +: 8])
                     res[8*k +: 8] = blend(start_col[i][8*k +: 8], tgt_col[i][8*k +: 8], p);
                  else
                     res[8*k +: 8] = cur_col[i][8*k +: 8];
               end
               cur_col[i] = res;
            end
         end
         if (any) begin
            filled = 0;
            for (int i = 0; i < n; i++) begin
               push_result(i, cur_col[i], 1, 0, 0);
               expected_colours[$].last_of_run = (i == n - 1);
            end
         end else begin
            filled = 1;
            push_result(0, 24'd0, 0, 1, 0);
         end
      end else if (rq.pixel_index >= n) begin
         push_result(0, 24'd0, 0, filled, 1);
      end else begin
         if (rq.opcode == lpc_pkg::OP_SET) begin
            cur_col[rq.pixel_index] = rq.colour;
            start_col[rq.pixel_index] = rq.colour;
            tgt_col[rq.pixel_index] = rq.colour;
         end else if (rq.opcode == lpc_pkg::OP_FADE) begin
            start_col[rq.pixel_index] = cur_col[rq.pixel_index];
            tgt_col[rq.pixel_index] = rq.colour;
            begin_ms[rq.pixel_index] = rq.fade_start;
            length_ms[rq.pixel_index] = rq.fade_duration;
         end
         push_result(rq.pixel_index, cur_col[rq.pixel_index], 0, filled, 0);
      end
   endtask

   // request driver
   initial begin
      req_ch.valid = 0; req_ch.opcode = 0; req_ch.pixel_index = 0; req_ch.red = 0;
      req_ch.green = 0; req_ch.blue = 0; req_ch.fade_start = 0; req_ch.fade_duration = 0;
      req_ch.now_ms = 0;
   end

   // advance when no request is driven or after a transfer seen at the last rising edge
   always @(negedge clock) begin
      request_type rq;
      if (!reset) begin
         if (!req_ch.valid || req_accepted) begin
            if (pending_requests.size() > 0 && !hold_req &&
                $urandom_range(99) >= idle_pct) begin
               rq = pending_requests.pop_front();
               req_ch.valid <= 1;
               req_ch.opcode <= rq.opcode;
               req_ch.pixel_index <= rq.pixel_index;
               {req_ch.red, req_ch.green, req_ch.blue} <= rq.colour;
               req_ch.fade_start <= rq.fade_start;
               req_ch.fade_duration <= rq.fade_duration;
               req_ch.now_ms <= rq.now_ms;
            end else begin
               req_ch.valid <= 0;
            end
         end
      end
   end

   // track accepted requests
   always @(posedge clock) begin
      request_type rq;
      req_accepted = !reset && req_ch.valid && req_ch.ready;
      if (req_accepted) begin
         rq.opcode = req_ch.opcode;
         rq.pixel_index = req_ch.pixel_index;
         rq.colour = {req_ch.red, req_ch.green, req_ch.blue};
         rq.fade_start = req_ch.fade_start;
         rq.fade_duration = req_ch.fade_duration;
         rq.now_ms = req_ch.now_ms;
         predict_crossfade(rq);
      end
   end

   // response sink and checker
   initial rsp_ch.ready = 0;
   always @(negedge clock)
      rsp_ch.ready <= !reset && ($urandom_range(99) >= idle_pct);

   always @(posedge clock) begin
      lpc_pkg::rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.out_index = rsp_ch.out_index;
         got.colour = {rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue};
         got.strip_changed = rsp_ch.strip_changed;
         got.all_filled = rsp_ch.all_filled;
         got.index_error = rsp_ch.index_error;
         got.last_of_run = rsp_ch.last_of_run;
         if (expected_colours.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_colours.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 40000) begin
         $display("tb_led_pixel_timed_crossfade_top failed");
         $finish;
      end
   end

   function automatic request_type make_req(logic [1:0] op, logic [7:0] idx,
                                            logic [23:0] col, logic [31:0] fs,
                                            logic [31:0] fd, logic [31:0] now);
      request_type rq;
      rq.opcode = op; rq.pixel_index = idx; rq.colour = col;
      rq.fade_start = fs; rq.fade_duration = fd; rq.now_ms = now;
      return rq;
   endfunction

   task automatic drain();
      while (pending_requests.size() > 0 || req_ch.valid || expected_colours.size() > 0)
         @(posedge clock);
      repeat (4000) @(posedge clock);
   endtask

   task automatic write_strip_len(logic [6:0] v);
      @(negedge clock);
      csr_ch.valid <= 1;
      csr_ch.pixel_count <= v;
      do @(posedge clock); while (!csr_ch.ready);
      strip_len = v;
      @(negedge clock);
      csr_ch.valid <= 0;
   endtask

   task automatic random_phase(int count, int n);
      logic [31:0] now;
      logic [1:0] op;
      int r;
      now = $urandom_range(1000);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            pending_requests.push_back(make_req(2'($urandom), 8'($urandom), 24'($urandom),
                                                $urandom, $urandom, $urandom));
         end else if (r < 35) begin
            now += $urandom_range(200);
            pending_requests.push_back(make_req(lpc_pkg::OP_TICK, 8'($urandom),
                                                24'($urandom), $urandom, $urandom, now));
         end else begin
            op = (r < 60) ? lpc_pkg::OP_FADE : (r < 75) ? lpc_pkg::OP_SET : lpc_pkg::OP_READ;
            pending_requests.push_back(make_req(op,
               ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(n - 1)),
               24'($urandom), now + $urandom_range(300) - 50,
               ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(600)), $urandom));
         end
      end
   endtask

   initial begin
      csr_ch.valid = 0;
      csr_ch.pixel_count = 0;
      strip_len = 64;
      filled = 0;
      for (int i = 0; i < 64; i++) begin
         cur_col[i] = 0; start_col[i] = 0; tgt_col[i] = 0; begin_ms[i] = 0; length_ms[i] = 0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset strip, extremes, snap, pending start, bad index
      pending_requests.push_back(make_req(lpc_pkg::OP_TICK, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(lpc_pkg::OP_SET, 0, 24'hffffff, 0, 0, 0));
      pending_requests.push_back(make_req(lpc_pkg::OP_READ, 63, 0, 0, 0, 0));
      pending_requests.push_back(make_req(lpc_pkg::OP_READ, 255, 24'hffffff, '1, '1, '1));
      pending_requests.push_back(make_req(lpc_pkg::OP_FADE, 64, 24'h123456, 0, 0, 0));
      pending_requests.push_back(make_req(lpc_pkg::OP_TICK, 0, 0, 0, 0, '1));
      pending_requests.push_back(make_req(lpc_pkg::OP_FADE, 1, 24'hff00ff, 100, 0, 0));
      pending_requests.push_back(make_req(lpc_pkg::OP_FADE, 2, 24'h00ff80, 100, 1000, 0));
      pending_requests.push_back(make_req(lpc_pkg::OP_FADE, 0, 24'h000000, '1, '1, 0));
      pending_requests.push_back(make_req(lpc_pkg::OP_TICK, 0, 0, 0, 0, 50));
      pending_requests.push_back(make_req(lpc_pkg::OP_TICK, 0, 0, 0, 0, 101));
      pending_requests.push_back(make_req(lpc_pkg::OP_TICK, 0, 0, 0, 0, 600));
      pending_requests.push_back(make_req(lpc_pkg::OP_TICK, 0, 0, 0, 0, 1100));
      pending_requests.push_back(make_req(lpc_pkg::OP_FADE, 0, 24'h000000, 0, 1, 0));
      pending_requests.push_back(make_req(lpc_pkg::OP_TICK, 0, 0, 0, 0, '1));
      pending_requests.push_back(make_req(lpc_pkg::OP_TICK, 0, 0, 0, 0, '1));
      drain();

      // pixel count extremes; first phase runs with no idling
      idle_pct = 0;
      write_strip_len(1);
      random_phase(40, 1);
      drain();
      idle_pct = 20;
      write_strip_len(0);
      pending_requests.push_back(make_req(lpc_pkg::OP_READ, 1, 0, 0, 0, 0));
      pending_requests.push_back(make_req(lpc_pkg::OP_TICK, 0, 0, 0, 0, 5));
      drain();
      write_strip_len(7'd127);
      random_phase(30, 64);
      drain();
      write_strip_len(5);
      random_phase(120, 5);
      // hold the sender mid-stream until every result is back
      while (pending_requests.size() > 60) @(posedge clock);
      hold_req = 1;
      while (expected_colours.size() > 0 || req_ch.valid) @(posedge clock);
      hold_req = 0;
      drain();
      write_strip_len(64);
      random_phase(100, 64);
      drain();

      if (mismatches == 0)
         $display("tb_led_pixel_timed_crossfade_top passed");
      else
         $display("tb_led_pixel_timed_crossfade_top failed");
      $finish;
   end
endmodule
